/* hw/rtl/kwsl_pkg.sv */
// Package for the keyword search unit with line and page tracking.
// Holds the widths, register indexes, marker-line states and byte helpers.
// No dependencies.
package kwsl_pkg;

	// Sizes of the search window and the counters.
	localparam int MAX_KEY   = 8;
	localparam int LINE_BITS = 24;
	localparam int PAGE_BITS = 16;

	// Fixed field widths at the ports.
	localparam int BYTE_W     = 8;
	localparam int OFFSET_W   = 32;
	localparam int LINE_OUT_W = 24;
	localparam int PAGE_OUT_W = 16;
	localparam int KEY_TEXT_W = 64;
	localparam int KEY_LEN_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// Derived sizes.
	localparam int WIN_W     = BYTE_W * MAX_KEY;
	localparam int KEY_IDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int NL_W      = $clog2(MAX_KEY + 1);
	localparam int SINCE_W   = 4;

	localparam logic [OFFSET_W-1:0]  POS_MAX      = '1;
	localparam logic [LINE_BITS-1:0] LINE_MAX     = '1;
	localparam logic [PAGE_BITS-1:0] PAGE_MAX     = '1;
	localparam logic [SINCE_W-1:0]   SINCE_MAX    = '1;
	localparam logic [31:0]          LINE_OUT_MAX = 32'((64'd1 << LINE_OUT_W) - 64'd1);
	localparam logic [31:0]          PAGE_OUT_MAX = 32'((64'd1 << PAGE_OUT_W) - 64'd1);

	localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_TEXT   = 1'b0,
		CFG_KEY_LENGTH = 1'b1
	} cfg_idx_t;

	// Progress through a candidate page-marker line.
	typedef enum logic [3:0] {
		PH_LEAD   = 4'b0001,
		PH_DIGITS = 4'b0010,
		PH_TRAIL  = 4'b0100,
		PH_FAIL   = 4'b1000
	} marker_phase_t;

	// One reported match.
	typedef struct packed {
		logic [OFFSET_W-1:0]   offset;
		logic [LINE_OUT_W-1:0] line;
		logic [PAGE_OUT_W-1:0] page;
	} match_t;

	// ASCII lowercasing of A-Z only.
	function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] c);
		lower_byte = c;
		if (c >= 8'd65 && c <= 8'd90) begin
			lower_byte = c + 8'd32;
		end
	endfunction

	// Whitespace is tab through carriage return, and the space.
	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		is_space = (c >= 8'd9 && c <= 8'd13) || (c == 8'd32);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		is_digit = (c >= 8'd48 && c <= 8'd57);
	endfunction

endpackage

/* hw/rtl/keyword_search_with_line_page_unit.sv */
// Top level of the keyword search unit: window compare, line and page tracking,
// and a two-entry result buffer (output register plus skid register).
// Depends on kwsl_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in       in         in_valid / in_stall    text_byte, first_of_file
//   out      out        out_valid / out_stall  match_offset, match_line, match_page
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its result, if any, shows on
// the output register in the next cycle unless the output register is still held
// by a stalled result. The window compare, counters and marker tracking all update
// in the cycle the byte is accepted. A match taken while the output is stalled goes
// to the skid register, and in_stall stays high while the skid register is full.
// Reset restores the key registers and all position state; cfg_ready is always high.
module keyword_search_with_line_page_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [kwsl_pkg::BYTE_W-1:0]          text_byte,
	input  logic                                 first_of_file,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [kwsl_pkg::OFFSET_W-1:0]        match_offset,
	output logic [kwsl_pkg::LINE_OUT_W-1:0]      match_line,
	output logic [kwsl_pkg::PAGE_OUT_W-1:0]      match_page,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kwsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kwsl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import kwsl_pkg::*;

	// Configuration registers.
	logic [KEY_TEXT_W-1:0] key_text_q;
	logic [KEY_LEN_W-1:0]  key_length_q;

	// Position state.
	logic [WIN_W-1:0]     recent_q;
	logic [SINCE_W-1:0]   since_q;
	logic [LINE_BITS-1:0] line_q;
	logic [PAGE_BITS-1:0] page_q;
	marker_phase_t        phase_q;
	logic [PAGE_BITS-1:0] mval_q;
	logic [OFFSET_W-1:0]  pos_q;
	logic [PAGE_BITS-1:0] trail_q [MAX_KEY];

	// Result buffer.
	logic   res_valid_q;
	match_t res_q;
	logic   skid_valid_q;
	match_t skid_q;

	// Combinational next state.
	logic [WIN_W-1:0]     recent_b, recent_n;
	logic [SINCE_W-1:0]   since_b, since_inc, since_n;
	logic [LINE_BITS-1:0] line_b, line_n;
	logic [PAGE_BITS-1:0] page_b, page_n;
	marker_phase_t        phase_b, phase_n;
	logic [PAGE_BITS-1:0] mval_b, mval_n;
	logic [OFFSET_W-1:0]  pos_b, pos_n;
	logic [PAGE_BITS-1:0] trail_b [MAX_KEY];
	logic [PAGE_BITS-1:0] trail_n [MAX_KEY];
	logic [BYTE_W-1:0]    key_lc [MAX_KEY];
	logic [MAX_KEY-1:0]   len_match;
	logic [KEY_LEN_W-1:0] len_eff;
	logic [KEY_IDX_W-1:0] len_idx;
	logic [NL_W-1:0]      nl_cnt;
	logic [PAGE_BITS+3:0] mval_x10;
	logic [LINE_BITS-1:0] line_hit;
	logic [31:0]          line_wide, page_wide;
	logic                 hit;
	match_t               res_new;
	logic                 in_xfer, out_xfer, res_push;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = res_valid_q;
	assign out_xfer  = res_valid_q && !out_stall;
	assign res_push  = in_xfer && hit;

	assign match_offset = res_q.offset;
	assign match_line   = res_q.line;
	assign match_page   = res_q.page;

	// Start of a new text resets all position state before the byte is taken.
	always_comb begin
		if (first_of_file) begin
			recent_b = '0;
			since_b  = '0;
			line_b   = LINE_BITS'(1);
			page_b   = PAGE_BITS'(1);
			phase_b  = PH_LEAD;
			mval_b   = '0;
			pos_b    = '0;
			for (int k = 0; k < MAX_KEY; k++) begin
				trail_b[k] = PAGE_BITS'(1);
			end
		end else begin
			recent_b = recent_q;
			since_b  = since_q;
			line_b   = line_q;
			page_b   = page_q;
			phase_b  = phase_q;
			mval_b   = mval_q;
			pos_b    = pos_q;
			for (int k = 0; k < MAX_KEY; k++) begin
				trail_b[k] = trail_q[k];
			end
		end
	end

	// Window shift and page trail shift.
	always_comb begin
		recent_n   = {recent_b[WIN_W-BYTE_W-1+BYTE_W-BYTE_W:0], lower_byte(text_byte)};
		trail_n[0] = page_b;
		for (int k = 1; k < MAX_KEY; k++) begin
			trail_n[k] = trail_b[k-1];
		end
		since_inc = (since_b == SINCE_MAX) ? since_b : since_b + SINCE_W'(1);
	end

	// Keyword compare for every possible length, then select the one in use.
	always_comb begin
		for (int i = 0; i < MAX_KEY; i++) begin
			key_lc[i] = lower_byte(key_text_q[BYTE_W*i +: BYTE_W]);
		end
		for (int j = 0; j < MAX_KEY; j++) begin
			len_match[j] = 1'b1;
			for (int i = 0; i <= j; i++) begin
				if (key_lc[i] != recent_n[BYTE_W*(j-i) +: BYTE_W]) begin
					len_match[j] = 1'b0;
				end
			end
		end
		len_eff = (key_length_q > KEY_LEN_W'(MAX_KEY)) ? KEY_LEN_W'(MAX_KEY) : key_length_q;
		len_idx = KEY_IDX_W'(len_eff - KEY_LEN_W'(1));
		hit = (len_eff != '0) && (since_inc >= SINCE_W'(len_eff)) && len_match[len_idx];
		// Newlines inside the keyword, before its last byte, move the line back.
		nl_cnt = '0;
		for (int i = 0; i < MAX_KEY; i++) begin
			if ((i + 1) < int'(len_eff) && key_lc[i] == CHAR_NEWLINE) begin
				nl_cnt = nl_cnt + NL_W'(1);
			end
		end
	end

	// Result fields, clamped to the port widths.
	always_comb begin
		res_new.offset = (pos_b == POS_MAX) ? POS_MAX
		                 : pos_b - OFFSET_W'(len_eff - KEY_LEN_W'(1));
		line_hit = (line_b == LINE_MAX) ? LINE_MAX : line_b - LINE_BITS'(nl_cnt);
		line_wide = 32'(line_hit);
		page_wide = 32'(trail_n[len_idx]);
		res_new.line = (line_wide > LINE_OUT_MAX) ? '1 : line_wide[LINE_OUT_W-1:0];
		res_new.page = (page_wide > PAGE_OUT_MAX) ? '1 : page_wide[PAGE_OUT_W-1:0];
		since_n = hit ? '0 : since_inc;
	end

	// Line counting and page-marker recognition on the raw byte.
	always_comb begin
		phase_n  = phase_b;
		mval_n   = mval_b;
		page_n   = page_b;
		line_n   = line_b;
		mval_x10 = {mval_b, 3'b000} + {2'b00, mval_b, 1'b0}
		           + (PAGE_BITS+4)'(text_byte[3:0]);
		if (text_byte == CHAR_NEWLINE) begin
			if (phase_b == PH_DIGITS || phase_b == PH_TRAIL) begin
				page_n = mval_b;
			end
			phase_n = PH_LEAD;
			mval_n  = '0;
			if (line_b != LINE_MAX) begin
				line_n = line_b + LINE_BITS'(1);
			end
		end else if (is_space(text_byte)) begin
			if (phase_b == PH_DIGITS) begin
				phase_n = PH_TRAIL;
			end
		end else if (is_digit(text_byte)) begin
			unique case (phase_b)
				PH_LEAD: begin
					phase_n = PH_DIGITS;
					mval_n  = PAGE_BITS'(text_byte[3:0]);
				end
				PH_DIGITS: begin
					mval_n = (mval_x10 > (PAGE_BITS+4)'(PAGE_MAX)) ? PAGE_MAX
					         : mval_x10[PAGE_BITS-1:0];
				end
				default: begin
					phase_n = PH_FAIL;
				end
			endcase
		end else begin
			phase_n = PH_FAIL;
		end
		pos_n = (pos_b == POS_MAX) ? pos_b : pos_b + OFFSET_W'(1);
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q   <= '0;
			key_length_q <= KEY_LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY_TEXT:   key_text_q   <= cfg_data[KEY_TEXT_W-1:0];
				CFG_KEY_LENGTH: key_length_q <= cfg_data[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Position state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			since_q  <= '0;
			line_q   <= LINE_BITS'(1);
			page_q   <= PAGE_BITS'(1);
			phase_q  <= PH_LEAD;
			mval_q   <= '0;
			pos_q    <= '0;
			for (int k = 0; k < MAX_KEY; k++) begin
				trail_q[k] <= PAGE_BITS'(1);
			end
		end else if (in_xfer) begin
			recent_q <= recent_n;
			since_q  <= since_n;
			line_q   <= line_n;
			page_q   <= page_n;
			phase_q  <= phase_n;
			mval_q   <= mval_n;
			pos_q    <= pos_n;
			for (int k = 0; k < MAX_KEY; k++) begin
				trail_q[k] <= trail_n[k];
			end
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || out_xfer) begin
			res_valid_q  <= skid_valid_q || res_push;
			skid_valid_q <= 1'b0;
		end else if (res_push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || out_xfer) begin
			res_q <= skid_valid_q ? skid_q : res_new;
		end else if (res_push) begin
			skid_q <= res_new;
		end
	end

endmodule
